// File: rtl/core/blake3_single_chunk_hash_core_macros.svh
// Assertion macros shared by the hash core RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef BLAKE3_SINGLE_CHUNK_HASH_CORE_MACROS_SVH
`define BLAKE3_SINGLE_CHUNK_HASH_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define B3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define B3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/core/b3sch_pkg.sv
// Shared types and constants for the single-chunk BLAKE3 hash core.
// No dependencies.
`default_nettype none
package b3sch_pkg;
  localparam logic [31:0] IV0 = 32'h6A09E667;
  localparam logic [31:0] IV1 = 32'hBB67AE85;
  localparam logic [31:0] IV2 = 32'h3C6EF372;
  localparam logic [31:0] IV3 = 32'hA54FF53A;
  localparam logic [31:0] IV4 = 32'h510E527F;
  localparam logic [31:0] IV5 = 32'h9B05688C;
  localparam logic [31:0] IV6 = 32'h1F83D9AB;
  localparam logic [31:0] IV7 = 32'h5BE0CD19;
  localparam logic [31:0] FLAG_CHUNK_START = 32'd1;
  localparam logic [31:0] FLAG_CHUNK_END = 32'd2;
  localparam logic [31:0] FLAG_ROOT = 32'd8;
  localparam int ROUNDS = 7;

  // One queued item: a byte and whether it ends the message.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        3'd0: r = IV0;
        3'd1: r = IV1;
        3'd2: r = IV2;
        3'd3: r = IV3;
        3'd4: r = IV4;
        3'd5: r = IV5;
        3'd6: r = IV6;
        default: r = IV7;
      endcase
      return r;
    end
  endfunction

  // Message word permutation: which word of the previous round feeds slot s in the next round.
  function automatic logic [3:0] perm(input logic [3:0] s);
    logic [3:0] r;
    begin
      unique case (s)
        4'd0: r = 4'd2;   4'd1: r = 4'd6;   4'd2: r = 4'd3;   4'd3: r = 4'd10;
        4'd4: r = 4'd7;   4'd5: r = 4'd0;   4'd6: r = 4'd4;   4'd7: r = 4'd13;
        4'd8: r = 4'd1;   4'd9: r = 4'd11;  4'd10: r = 4'd12; 4'd11: r = 4'd5;
        4'd12: r = 4'd9;  4'd13: r = 4'd14; 4'd14: r = 4'd15; default: r = 4'd8;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/b3sch_front.sv
// Front end: input skid queue of two items between the stream port and the engine.
// Depends on b3sch_pkg.
`default_nettype none
module b3sch_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire b3sch_pkg::item_t in_item,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output b3sch_pkg::item_t     q_item
);
  b3sch_pkg::item_t slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
  end

  // Pointer and occupancy control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "blake3_single_chunk_hash_core_macros.svh"
  `B3_ASSERT_IMP(a_no_overflow, clk, rst, count == 2'd2, !push, "queue overflow")
  `B3_ASSERT_NEXT(a_count_track, clk, rst, push && !pop && count == 2'd0, count == 2'd1, "count slip")
  `B3_ASSERT_IMP(a_ready_when_empty, clk, rst, count == 2'd0, in_ready, "empty queue not ready")
endmodule
`default_nettype wire

// File: rtl/core/b3sch_engine.sv
// Back end: block buffer, shared quarter-round (G) unit and digest output register.
// Depends on b3sch_pkg.
`default_nettype none
module b3sch_engine #(
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire b3sch_pkg::item_t q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           digest_word,
  output logic [2:0]            word_index,
  output logic                  last_word,
  output logic                  too_long
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MIX = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]  state;
  logic [31:0] cv [8];
  logic [31:0] blk [16];
  logic [31:0] v [16];
  logic [31:0] m [16];
  logic [6:0]  fill_count;
  logic        block_done;
  logic [10:0] byte_total;
  logic        final_pass;
  logic        pend_byte;
  logic [7:0]  pend_data;
  logic        pend_last;
  logic [2:0]  g_idx;
  logic [2:0]  round;
  logic [2:0]  out_idx;
  logic        long_flag;

  // Current G lane indices.
  logic [3:0] ia, ib, ic, id;
  always_comb begin
    unique case (g_idx)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
  end

  // One full G function per cycle.
  logic [31:0] mx, my, a1, d1, c1, b1, a2, d2, c2, b2, t0, t1, t2, t3;
  always_comb begin
    mx = m[{g_idx, 1'b0}];
    my = m[{g_idx, 1'b1}];
    a1 = v[ia] + v[ib] + mx;
    t0 = v[id] ^ a1;
    d1 = {t0[15:0], t0[31:16]};
    c1 = v[ic] + d1;
    t1 = v[ib] ^ c1;
    b1 = {t1[11:0], t1[31:12]};
    a2 = a1 + b1 + my;
    t2 = d1 ^ a2;
    d2 = {t2[7:0], t2[31:8]};
    c2 = c1 + d2;
    t3 = b1 ^ c2;
    b2 = {t3[6:0], t3[31:7]};
  end

  logic [31:0] flags_w;
  logic [6:0]  cmp_len;
  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= 7'd0;
      block_done <= 1'b0;
      byte_total <= 11'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) cv[i] <= b3sch_pkg::iv_word(3'(i));
      for (int i = 0; i < 16; i++) blk[i] <= 32'd0;
    end else begin
      unique case (state)
        // Take an item: store byte or start a compression.
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.has_byte && byte_total != 11'h7FF) byte_total <= byte_total + 11'd1;
            if (q_item.has_byte && fill_count[6]) begin
              // Full buffer: compress it first and hold the new byte aside.
              pend_byte <= 1'b1;
              pend_data <= q_item.data_byte;
              pend_last <= q_item.last;
              final_pass <= 1'b0;
              cmp_len <= 7'd64;
              flags_w <= block_done ? 32'd0 : b3sch_pkg::FLAG_CHUNK_START;
              state <= S_LOAD;
            end else begin
              if (q_item.has_byte) begin
                blk[fill_count[5:2]][{fill_count[1:0], 3'b000} +: 8] <= q_item.data_byte;
                fill_count <= fill_count + 7'd1;
              end
              pend_byte <= 1'b0;
              final_pass <= q_item.last;
              if (q_item.last) begin
                cmp_len <= fill_count + {6'd0, q_item.has_byte};
                flags_w <= (block_done ? 32'd0 : b3sch_pkg::FLAG_CHUNK_START)
                           | b3sch_pkg::FLAG_CHUNK_END | b3sch_pkg::FLAG_ROOT;
                state <= S_LOAD;
              end
            end
          end
        end
        // Initialize the working state.
        S_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= cv[i];
          for (int i = 0; i < 4; i++) v[8 + i] <= b3sch_pkg::iv_word(3'(i));
          v[12] <= 32'd0;
          v[13] <= 32'd0;
          v[14] <= {25'd0, cmp_len};
          v[15] <= flags_w;
          for (int i = 0; i < 16; i++) m[i] <= blk[i];
          g_idx <= 3'd0;
          round <= 3'd0;
          state <= S_MIX;
        end
        // Eight G steps per round, message permuted after each round.
        S_MIX: begin
          v[ia] <= a2;
          v[ib] <= b2;
          v[ic] <= c2;
          v[id] <= d2;
          g_idx <= g_idx + 3'd1;
          if (g_idx == 3'd7) begin
            for (int i = 0; i < 16; i++) m[i] <= m[b3sch_pkg::perm(4'(i))];
            round <= round + 3'd1;
            if (round == 3'(b3sch_pkg::ROUNDS - 1)) state <= S_DONE;
          end
        end
        // Fold the state; either chain on or present the digest.
        S_DONE: begin
          for (int i = 0; i < 8; i++) cv[i] <= v[i] ^ v[i + 8];
          if (final_pass) begin
            long_flag <= (byte_total > 11'(MAX_MESSAGE_BYTES));
            out_idx <= 3'd0;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            block_done <= 1'b1;
            for (int i = 1; i < 16; i++) blk[i] <= 32'd0;
            blk[0] <= {24'd0, pend_data};
            fill_count <= 7'd1;
            if (pend_byte && pend_last) begin
              cmp_len <= 7'd1;
              flags_w <= b3sch_pkg::FLAG_CHUNK_END | b3sch_pkg::FLAG_ROOT;
              final_pass <= 1'b1;
              state <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // Hand out eight digest words, then return to reset state.
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
              fill_count <= 7'd0;
              block_done <= 1'b0;
              byte_total <= 11'd0;
              for (int i = 0; i < 8; i++) cv[i] <= b3sch_pkg::iv_word(3'(i));
              for (int i = 0; i < 16; i++) blk[i] <= 32'd0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest_word = cv[out_idx];
  assign word_index = out_idx;
  assign last_word = (out_idx == 3'd7);
  assign too_long = long_flag;

  `include "blake3_single_chunk_hash_core_macros.svh"
  `B3_ASSERT_IMP(a_out_only_in_out, clk, rst, out_valid, state == S_OUT, "stray output")
  `B3_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill_count <= 7'd64, "fill count overrun")
  `B3_ASSERT_NEXT(a_mix_follows_load, clk, rst, state == S_LOAD, state == S_MIX, "load not followed by mix")
endmodule
`default_nettype wire

// File: rtl/core/blake3_single_chunk_hash_core.sv
// Single-chunk BLAKE3 hash core: top level joining input queue and compression engine.
// Depends on b3sch_pkg, b3sch_front and b3sch_engine.
//
// Usage: message bytes enter on the s_axis channel one item per handshake.
// s_axis_tuser marks a valid byte (has_byte); s_axis_tlast ends the message.
// An item with tuser low and tlast low is dropped; tlast with tuser low
// finishes the message without a byte, so the empty message is supported.
// On the last item eight m_axis items come out: the digest words in order,
// tuser carrying the word index and too_long, tlast on word 7.
// Flow: a byte that fits the block buffer is stored as the engine takes it
// from the two-entry input queue. The 65th byte of a block triggers one
// compression: a load state, 7 rounds of 8 steps of the single G unit
// and a fold state; no items are taken meanwhile. Finalization adds one
// more compression before the first word shows, or two when the closing
// item carries the 65th byte of a block.
// Reset clears the queue and restores the IV chaining value; after each
// digest the engine returns to that same state. While m_axis_tready is low
// the engine holds the current word and takes no further items; the input
// queue still absorbs up to two.
`default_nettype none
module blake3_single_chunk_hash_core #(
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [3:0]       m_axis_tuser,   // [2:0] word_index, [3] too_long
  output logic             m_axis_tlast
);
  b3sch_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [2:0] word_index;
  logic too_long;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.has_byte = s_axis_tuser;
  assign in_item.last = s_axis_tlast;

  // Input queue.
  b3sch_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  // Compression engine.
  b3sch_engine #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_engine (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(m_axis_tdata), .word_index(word_index),
    .last_word(m_axis_tlast), .too_long(too_long)
  );

  assign m_axis_tuser = {too_long, word_index};
endmodule
`default_nettype wire

// File: verif/blake3_single_chunk_hash_core_checker.sv
// Digest checker for the single-chunk BLAKE3 hash core: watches both streams,
// predicts digest words from the accepted message bytes and compares them.
// Depends on b3sch_pkg for the IV, flag and round-count constants.
`timescale 1ns / 100ps
module blake3_single_chunk_hash_core_checker #(
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          words_pending
);
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
    logic        too_long;
  } digest_word_t;

  localparam int unsigned SHUFFLE [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  logic [31:0]  chain [8];
  logic [7:0]   msg_block [64];
  int unsigned  fill;
  logic         first_done;
  int unsigned  total;
  digest_word_t digest_q [$];

  assign words_pending = digest_q.size();

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One G step on the working state.
  task automatic mix_g(inout logic [31:0] v [16], input int a, b, c, d,
                       input logic [31:0] x, y);
    v[a] = v[a] + v[b] + x;
    v[d] = rotr(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y;
    v[d] = rotr(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 7);
  endtask

  // Compress the current block into eight output words.
  task automatic compress(input logic [31:0] len, input logic [31:0] flags,
                          output logic [31:0] res [8]);
    logic [31:0] m [16];
    logic [31:0] t [16];
    logic [31:0] v [16];
    for (int i = 0; i < 16; i++)
      m[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    v[8] = b3sch_pkg::IV0; v[9] = b3sch_pkg::IV1;
    v[10] = b3sch_pkg::IV2; v[11] = b3sch_pkg::IV3;
    v[12] = '0; v[13] = '0; v[14] = len; v[15] = flags;
    for (int r = 0; r < b3sch_pkg::ROUNDS; r++) begin
      mix_g(v, 0, 4, 8, 12, m[0], m[1]);
      mix_g(v, 1, 5, 9, 13, m[2], m[3]);
      mix_g(v, 2, 6, 10, 14, m[4], m[5]);
      mix_g(v, 3, 7, 11, 15, m[6], m[7]);
      mix_g(v, 0, 5, 10, 15, m[8], m[9]);
      mix_g(v, 1, 6, 11, 12, m[10], m[11]);
      mix_g(v, 2, 7, 8, 13, m[12], m[13]);
      mix_g(v, 3, 4, 9, 14, m[14], m[15]);
      for (int i = 0; i < 16; i++) t[i] = m[SHUFFLE[i]];
      m = t;
    end
    for (int i = 0; i < 8; i++) res[i] = v[i] ^ v[i+8];
  endtask

  task automatic clear_message();
    chain = '{b3sch_pkg::IV0, b3sch_pkg::IV1, b3sch_pkg::IV2, b3sch_pkg::IV3,
              b3sch_pkg::IV4, b3sch_pkg::IV5, b3sch_pkg::IV6, b3sch_pkg::IV7};
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    fill = 0;
    first_done = 1'b0;
    total = 0;
  endtask

  // Absorb one accepted item and queue the digest when it ends the message.
  task automatic absorb_item(logic [7:0] data, logic has, logic fin);
    logic [31:0] res [8];
    logic [31:0] flags;
    if (has) begin
      if (fill >= 64) begin
        compress(32'd64, first_done ? 32'd0 : b3sch_pkg::FLAG_CHUNK_START, res);
        chain = res;
        first_done = 1'b1;
        fill = 0;
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
      end
      msg_block[fill] = data;
      fill++;
      if (total < 2047) total++;
    end
    if (fin) begin
      flags = (first_done ? 32'd0 : b3sch_pkg::FLAG_CHUNK_START)
              | b3sch_pkg::FLAG_CHUNK_END | b3sch_pkg::FLAG_ROOT;
      compress(fill, flags, res);
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{res[i], 3'(i), i == 7, total > MAX_MESSAGE_BYTES});
      clear_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: digest mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_message();
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 32'd0);
        end else begin
          exp_w = digest_q.pop_front();
          if (m_axis_tdata !== exp_w.word) report_mismatch("word", m_axis_tdata, exp_w.word);
          if (m_axis_tuser[2:0] !== exp_w.index)
            report_mismatch("index", m_axis_tuser[2:0], exp_w.index);
          if (m_axis_tuser[3] !== exp_w.too_long)
            report_mismatch("too_long", m_axis_tuser[3], exp_w.too_long);
          if (m_axis_tlast !== exp_w.is_last)
            report_mismatch("last", m_axis_tlast, exp_w.is_last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end
endmodule

// File: verif/blake3_single_chunk_hash_core_test.sv
// Testbench top for the single-chunk BLAKE3 hash core: drives messages of
// varied lengths with random idling and gives the verdict.
// Depends on the core RTL, b3sch_pkg and blake3_single_chunk_hash_core_checker.
`timescale 1ns / 100ps
module blake3_single_chunk_hash_core_test;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          words_pending;
  bit          calm_phase;
  bit          hold_sink;

  blake3_single_chunk_hash_core i_dut (.*);
  blake3_single_chunk_hash_core_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one item, with a random idle burst first unless in the calm phase.
  task automatic send_item(logic [7:0] data, logic has, logic fin);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // A message of random bytes, sometimes with empty items mixed in.
  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the calm phase.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_sink = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int wait_cycles;
    rst = 1'b1;
    calm_phase = 1'b0;
    hold_sink = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, extreme bytes, block boundaries.
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b1);
    send_message(64, 1'b0);
    send_message(65, 1'b0);
    hold_sink = 1'b1;
    send_message(3, 1'b0);
    send_message(2, 1'b0);
    send_message(1, 1'b0);

    // Random short messages.
    for (int n = 0; n < 12; n++) begin
      if (n == 9) calm_phase = 1'b1;
      send_message($urandom_range(0, 8), $urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (words_pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
